// ----- design/tag_node_bit_matrix_engine_defines.svh -----
// Assertion macros shared by the tag/node matrix engine.
`ifndef TAG_NODE_BIT_MATRIX_ENGINE_DEFINES_SVH
`define TAG_NODE_BIT_MATRIX_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TNBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TNBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tnbm_pkg.sv -----
// Package: types, constants and helpers of the tag/node matrix engine.
package tnbm_pkg;

	localparam int TAG_SLOTS  = 64;
	localparam int NODE_SLOTS = 64;
	localparam int ROW_W      = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int MODE_W     = 3;

	localparam int TAG_LIM  = (TAG_SLOTS < ROW_W) ? TAG_SLOTS : ROW_W;
	localparam int NODE_LIM = (NODE_SLOTS < ROW_W) ? NODE_SLOTS : ROW_W;

	localparam logic [MODE_W-1:0] MODE_ATTACH    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DETACH    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLR_ROW   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLR_COL   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NODES     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TAGS      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd6;

	localparam logic CFG_TAG_SLOTS  = 1'b0;
	localparam logic CFG_NODE_SLOTS = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  tag_id;
		logic [IDX_W-1:0]  node_id;
		logic              last_tag;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] hit_index;
		logic             found;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [ROW_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] tb;
		logic [CNT_W-1:0] nb;
	} bounds_t;

	function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [ROW_W-1:0] m;
		for (int i = 0; i < ROW_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] used,
		input logic [CNT_W-1:0] lim);
		return (used < lim) ? used : lim;
	endfunction

endpackage

// ----- design/tag_node_bit_matrix_engine.sv -----
// Top level of the tag/node matrix engine: configuration, row memory, sequencer.
//
// Input channel (in_valid/in_stall/in_data): one transaction per command (attach,
// detach, clear row, clear column, list nodes of a tag, list tags of a node,
// intersect). Output channel (out_valid/out_stall/out_data): one transaction per
// hit in ascending index order, last flagged; an empty list gives found=0, last=1.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): slot counts that bound
// scans; cfg_ready is always high, write only while the block is idle.
// Attach/detach read the row, then write it back; a row clear writes zeros when
// accepted; column clear and tags of node walk rows 0 to tag_bound-1, one row per
// cycle, tags of node then emitting; nodes of tag reads one row, then emits, and
// intersect does so on its last tag. Emission scans up to 64 bit positions, one
// per cycle while the receiver does not stall.
// Commands are accepted only while idle.
// Reset clears the matrix at once through per-row valid bits, empties the
// intersection and sets both slot counts to 64. A stall on the output holds the
// registered result and pauses emission.
`include "tag_node_bit_matrix_engine_defines.svh"

module tag_node_bit_matrix_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  tnbm_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output tnbm_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_index,
	input  logic [tnbm_pkg::CNT_W-1:0]     cfg_data
);
	import tnbm_pkg::*;

	logic [CNT_W-1:0] tag_slots_q;
	logic [CNT_W-1:0] node_slots_q;
	bounds_t          bounds;
	mem_req_t         mem_req;
	logic [ROW_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	// Hold the slot counts; a write lands on the edge where valid and ready meet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_slots_q  <= CNT_W'(64);
			node_slots_q <= CNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TAG_SLOTS:  tag_slots_q  <= cfg_data;
				CFG_NODE_SLOTS: node_slots_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Clamp the scan bounds to the matrix size.
	assign bounds.tb = clamp_count(tag_slots_q, CNT_W'(TAG_LIM));
	assign bounds.nb = clamp_count(node_slots_q, CNT_W'(NODE_LIM));

	tnbm_row_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	tnbm_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.bounds    (bounds),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// An empty answer is always a single, final result at index zero.
	`TNBM_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.found, out_data.last && (out_data.hit_index == '0), "empty result not final or nonzero index")
	// A column walk never writes the row it is reading in the same cycle.
	`TNBM_ASSERT_NOW(a_no_rw_collide, mem_req.wr_en && mem_req.rd_en && !(in_valid && !in_stall), mem_req.wr_addr != mem_req.rd_addr, "row read and write collide")
	// Accepting a row command always takes the sequencer out of idle.
	`TNBM_ASSERT_NEXT(a_accept_reads, in_valid && !in_stall && (in_data.mode == MODE_NODES || in_data.mode == MODE_INTERSECT), in_stall, "row command did not occupy sequencer")

endmodule

// ----- design/tnbm_row_mem.sv -----
// Matrix row memory: one write and one registered read port, per-row valid bits.
module tnbm_row_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tnbm_pkg::mem_req_t         req,
	output logic [tnbm_pkg::ROW_W-1:0] rd_data
);
	import tnbm_pkg::*;

	localparam int DEPTH = 1 << IDX_W;

	logic [ROW_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_valid_q;
	logic [ROW_W-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// A row never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= row_valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- design/tnbm_seq.sv -----
// Sequencer: read-modify-write of matrix rows, scans and result emission.
module tnbm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tnbm_pkg::in_item_t         in_data,
	input  tnbm_pkg::bounds_t          bounds,
	output tnbm_pkg::mem_req_t         mem_req,
	input  logic [tnbm_pkg::ROW_W-1:0] rd_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tnbm_pkg::out_item_t        out_data
);
	import tnbm_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WB   = 3'd1;
	localparam logic [2:0] S_ROW  = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]       state_q;
	in_item_t         item_q;
	logic [ROW_W-1:0] vec_q;
	logic [ROW_W-1:0] imask_q;
	logic             iactive_q;
	logic [CNT_W-1:0] ptr_q;
	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] hit_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             accept;
	logic             in_t_ok;
	logic             in_n_ok;
	logic             t_ok;
	logic             n_ok;
	logic [ROW_W-1:0] bit_vec;
	logic [ROW_W-1:0] row;
	logic [ROW_W-1:0] imask_next;
	logic             out_free;
	logic             walk_issue;
	logic             last_hit;
	logic             emit_go;

	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && (state_q == S_IDLE);
	assign in_t_ok    = (int'(in_data.tag_id) < TAG_SLOTS);
	assign in_n_ok    = (int'(in_data.node_id) < NODE_SLOTS);
	assign t_ok       = (int'(item_q.tag_id) < TAG_SLOTS);
	assign n_ok       = (int'(item_q.node_id) < NODE_SLOTS);
	assign bit_vec    = ROW_W'(1) << item_q.node_id;
	assign row        = t_ok ? rd_data : '0;
	assign imask_next = iactive_q ? (imask_q & row) : row;
	assign out_free   = !out_valid_q || !out_stall;
	assign walk_issue = (state_q == S_WALK) && (ptr_q < bounds.tb);
	assign last_hit   = (vec_q[ROW_W-1:1] == '0);
	assign emit_go    = (state_q == S_EMIT) && out_free && ((vec_q == '0) || vec_q[0]);

	// Items are taken only when idle, so a row write always lands before the
	// next item reads; inside a column walk the read and write rows differ.
	always_comb begin
		mem_req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = in_data.tag_id;
					if (in_data.mode == MODE_CLR_ROW && in_t_ok) begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = in_data.tag_id;
					end
				end
			end
			S_WB: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = item_q.tag_id;
				mem_req.wr_data = (item_q.mode == MODE_ATTACH) ? (rd_data | bit_vec)
					: (rd_data & ~bit_vec);
			end
			S_WALK: begin
				mem_req.rd_en   = walk_issue;
				mem_req.rd_addr = ptr_q[IDX_W-1:0];
				if (pend_s1 && item_q.mode == MODE_CLR_COL && n_ok) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = idx_s1;
					mem_req.wr_data = rd_data & ~bit_vec;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			item_q    <= '0;
			vec_q     <= '0;
			imask_q   <= '0;
			iactive_q <= 1'b0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			idx_s1    <= '0;
			hit_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q  <= in_data;
						vec_q   <= '0;
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= '0;
						case (in_data.mode)
							MODE_ATTACH, MODE_DETACH: begin
								state_q <= (in_t_ok && in_n_ok) ? S_WB : S_IDLE;
							end
							MODE_CLR_COL, MODE_TAGS: begin
								state_q <= S_WALK;
							end
							MODE_NODES, MODE_INTERSECT: begin
								state_q <= S_ROW;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_WB: begin
					state_q <= S_IDLE;
				end
				S_ROW: begin
					if (item_q.mode == MODE_NODES) begin
						vec_q   <= row & low_mask(bounds.nb);
						state_q <= S_EMIT;
					end else if (item_q.last_tag) begin
						vec_q     <= imask_next & low_mask(bounds.nb);
						imask_q   <= '0;
						iactive_q <= 1'b0;
						state_q   <= S_EMIT;
					end else begin
						imask_q   <= imask_next;
						iactive_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_WALK: begin
					pend_s1 <= walk_issue;
					idx_s1  <= ptr_q[IDX_W-1:0];
					if (walk_issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (pend_s1 && item_q.mode == MODE_TAGS && n_ok) begin
						vec_q[idx_s1] <= rd_data[item_q.node_id];
					end
					if (!walk_issue && !pend_s1) begin
						state_q <= (item_q.mode == MODE_TAGS) ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (vec_q == '0) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else if (!vec_q[0] || out_free) begin
						vec_q <= vec_q >> 1;
						hit_q <= hit_q + IDX_W'(1);
						if (vec_q[0] && last_hit) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_q.hit_index <= (vec_q == '0) ? '0 : hit_q;
			out_q.found     <= (vec_q != '0);
			out_q.last      <= (vec_q == '0) || last_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
